// ===== design/pket_pkg.sv =====
// ----------------------------------------------------------------------------
// pket_pkg
// Shared widths, defaults and operation codes of the pressed-key event table.
// ----------------------------------------------------------------------------
package pket_pkg;

	localparam int OP_W            = 3;
	localparam int CODE_W          = 16;
	localparam int VALUE_W         = 32;
	localparam int INDEX_W         = 8;
	localparam int MAX_ENTRIES_DEF = 16;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 3'd0,
		OP_FIND   = 3'd1,
		OP_REMOVE = 3'd2,
		OP_GET    = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

endpackage

// ===== design/pket_ram.sv =====
// ----------------------------------------------------------------------------
// pket_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pket_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== design/pressed_key_event_table.sv =====
// ----------------------------------------------------------------------------
// pressed_key_event_table
// Packed, ordered list of key events held in one RAM, with add, find, remove,
// get and clear operations; one result word per input word.
//
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    op, key_code, key_value, index
// out      out  out_valid/out_ready  ok, found_code, found_value, entry_count
//
// add, clear, undefined ops, gets past the count, lookups in an empty list: no RAM read.
// get in range: one RAM read. find: reads from position 0 up to the hit,
// walking the single RAM read port one entry per cycle; a miss walks all.
// remove: as find, then each later entry is moved down one place (read then write).
// reset clears the count and control only; no clearing pass over the RAM.
// a stalled output holds the result; the next word is taken once it is loaded.
// ----------------------------------------------------------------------------
module pressed_key_event_table #(
	parameter int MAX_ENTRIES = pket_pkg::MAX_ENTRIES_DEF,
	localparam int AW         = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int CW         = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [pket_pkg::OP_W-1:0]           op,
	input  logic [pket_pkg::CODE_W-1:0]         key_code,
	input  logic signed [pket_pkg::VALUE_W-1:0] key_value,
	input  logic [pket_pkg::INDEX_W-1:0]        index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                ok,
	output logic [pket_pkg::CODE_W-1:0]         found_code,
	output logic signed [pket_pkg::VALUE_W-1:0] found_value,
	output logic [CW-1:0]                       entry_count
);

	localparam int EW = pket_pkg::CODE_W + pket_pkg::VALUE_W;
	localparam int XW = pket_pkg::INDEX_W + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_GET,
		S_GETW,
		S_DONE
	} state_t;

	state_t                        state_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 rptr_q;
	logic [AW-1:0]                 cptr_q;
	logic [AW-1:0]                 wptr_q;
	logic                          pend_q;
	logic                          is_remove_q;
	logic [pket_pkg::CODE_W-1:0]   key_q;
	logic [pket_pkg::INDEX_W-1:0]  idx_q;
	logic                          res_ok_q;
	logic [pket_pkg::CODE_W-1:0]   res_code_q;
	logic [pket_pkg::VALUE_W-1:0]  res_value_q;
	logic                          out_valid_q;
	logic                          out_ok_q;
	logic [pket_pkg::CODE_W-1:0]   out_code_q;
	logic [pket_pkg::VALUE_W-1:0]  out_value_q;
	logic [CW-1:0]                 out_count_q;

	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic [EW-1:0]                 wr_data;
	logic [AW-1:0]                 rd_addr;
	logic [EW-1:0]                 rd_data;
	logic [pket_pkg::CODE_W-1:0]   rd_code;
	logic [pket_pkg::VALUE_W-1:0]  rd_value;
	logic                          full;
	logic                          last;
	logic                          rd_go;
	logic                          accept;

	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CW'(MAX_ENTRIES));
	assign last     = (CW'(cptr_q) == (count_q - CW'(1)));
	assign rd_go    = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (rptr_q < count_q);
	assign rd_code  = rd_data[EW-1:pket_pkg::VALUE_W];
	assign rd_value = rd_data[pket_pkg::VALUE_W-1:0];
	assign rd_addr  = (state_q == S_GET) ? idx_q[AW-1:0] : rptr_q[AW-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = {key_code, key_value};
		if (state_q == S_SHIFT) begin
			wr_en   = 1'b1;
			wr_addr = wptr_q;
			wr_data = rd_data;
		end else if (accept && (pket_pkg::op_t'(op) == pket_pkg::OP_ADD) && !full) begin
			wr_en = 1'b1;
		end
	end

	pket_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rptr_q      <= '0;
			cptr_q      <= '0;
			wptr_q      <= '0;
			pend_q      <= 1'b0;
			is_remove_q <= 1'b0;
			key_q       <= '0;
			idx_q       <= '0;
			res_ok_q    <= 1'b0;
			res_code_q  <= '0;
			res_value_q <= '0;
			out_valid_q <= 1'b0;
			out_ok_q    <= 1'b0;
			out_code_q  <= '0;
			out_value_q <= '0;
			out_count_q <= '0;
		end else begin
			pend_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (rd_go) begin
				pend_q <= 1'b1;
				cptr_q <= rptr_q[AW-1:0];
				rptr_q <= rptr_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						key_q       <= key_code;
						idx_q       <= index;
						rptr_q      <= '0;
						is_remove_q <= (pket_pkg::op_t'(op) == pket_pkg::OP_REMOVE);
						res_ok_q    <= 1'b0;
						res_code_q  <= '0;
						res_value_q <= '0;
						state_q     <= S_DONE;
						unique case (pket_pkg::op_t'(op))
							pket_pkg::OP_ADD: begin
								if (!full) begin
									count_q  <= count_q + CW'(1);
									res_ok_q <= 1'b1;
								end
							end
							pket_pkg::OP_FIND, pket_pkg::OP_REMOVE: begin
								if (count_q != '0) begin
									state_q <= S_SCAN;
								end
							end
							pket_pkg::OP_GET: begin
								if (XW'(index) < XW'(count_q)) begin
									state_q <= S_GET;
								end
							end
							pket_pkg::OP_CLEAR: begin
								count_q  <= '0;
								res_ok_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (pend_q) begin
						if (rd_code == key_q) begin
							if (!is_remove_q) begin
								res_ok_q    <= 1'b1;
								res_code_q  <= rd_code;
								res_value_q <= rd_value;
								state_q     <= S_DONE;
							end else if (last) begin
								count_q  <= count_q - CW'(1);
								res_ok_q <= 1'b1;
								state_q  <= S_DONE;
							end else begin
								wptr_q  <= cptr_q;
								state_q <= S_SHIFT;
							end
						end else if (last) begin
							state_q <= S_DONE;
						end
					end
				end
				S_SHIFT: begin
					if (last) begin
						count_q  <= count_q - CW'(1);
						res_ok_q <= 1'b1;
						state_q  <= S_DONE;
					end else begin
						wptr_q <= cptr_q;
					end
				end
				S_GET: begin
					state_q <= S_GETW;
				end
				S_GETW: begin
					res_ok_q    <= 1'b1;
					res_code_q  <= rd_code;
					res_value_q <= rd_value;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_ok_q    <= res_ok_q;
						out_code_q  <= res_code_q;
						out_value_q <= res_value_q;
						out_count_q <= count_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign ok          = out_ok_q;
	assign found_code  = out_code_q;
	assign found_value = out_value_q;
	assign entry_count = out_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count above capacity");

	a_shift_data: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> pend_q)
		else $error("shift without read data");

	a_pend_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q && (state_q == S_SCAN || state_q == S_SHIFT) |-> CW'(cptr_q) < count_q)
		else $error("read beyond held entries");

	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pket_pkg::op_t'(op) == pket_pkg::OP_ADD && !full
		|=> count_q == $past(count_q) + CW'(1))
		else $error("add did not grow the list");

endmodule
